FILE: rtl/core/icsc_pkg.sv
`default_nettype none
package icsc_pkg;

	localparam int unsigned CLASS_W    = 3;
	localparam int unsigned ISSUE_W    = 16;
	localparam int unsigned WEIGHT_W   = 7;
	localparam int unsigned COST_W     = 16;
	localparam int unsigned WEIGHTED_W = 22;
	localparam int unsigned TOTAL_W    = 48;
	localparam int unsigned CFG_IDX_W  = 3;
	localparam int unsigned NUM_CLASSES       = 8;
	localparam int unsigned NUM_CYCLE_CLASSES = 6;
	localparam int unsigned SLOT_W            = 3;

	localparam logic [WEIGHTED_W-1:0] WEIGHTED_MAX = {WEIGHTED_W{1'b1}};
	localparam logic [COST_W-1:0]     COST_RESET   = COST_W'(1);

	typedef enum logic [CLASS_W-1:0] {
		CLS_SCALAR_ALU = 3'd0,
		CLS_SCALAR_MEM = 3'd1,
		CLS_VECTOR_ALU = 3'd2,
		CLS_VECTOR_MEM = 3'd3,
		CLS_BRANCH     = 3'd4,
		CLS_SYNC       = 3'd5,
		CLS_TENSOR     = 3'd6,
		CLS_OTHER      = 3'd7
	} instr_class_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_TENSOR_COST     = 3'd0,
		REG_SCALAR_MEM_COST = 3'd1,
		REG_VECTOR_MEM_COST = 3'd2,
		REG_DEFAULT_COST    = 3'd3
	} cfg_reg_t;

	typedef struct packed {
		logic [CLASS_W-1:0]  instr_class;
		logic [ISSUE_W-1:0]  issue_cnt;
		logic [WEIGHT_W-1:0] unit_weight;
	} in_beat_t;

	typedef struct packed {
		logic [CLASS_W-1:0]    instr_class;
		logic [COST_W-1:0]     cost;
		logic [WEIGHTED_W-1:0] weighted;
	} cost_beat_t;

	typedef struct packed {
		logic       cycle_hit;
		logic [SLOT_W-1:0] slot;
	} slot_t;

	typedef struct packed {
		logic       adv;
		cost_beat_t beat;
	} accum_ctl_t;

	function automatic slot_t cycle_slot(input logic [CLASS_W-1:0] cls);
		slot_t s;
		s.cycle_hit = 1'b1;
		s.slot      = '0;
		case (cls)
			CLS_SCALAR_ALU: s.slot = SLOT_W'(0);
			CLS_SCALAR_MEM: s.slot = SLOT_W'(1);
			CLS_VECTOR_ALU: s.slot = SLOT_W'(2);
			CLS_VECTOR_MEM: s.slot = SLOT_W'(3);
			CLS_SYNC:       s.slot = SLOT_W'(4);
			CLS_TENSOR:     s.slot = SLOT_W'(5);
			default:        s.cycle_hit = 1'b0;
		endcase
		return s;
	endfunction

endpackage
`default_nettype wire

FILE: rtl/core/icsc_cost_stage.sv
`default_nettype none
module icsc_cost_stage (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           cfg_wr_en,
	input  wire logic [icsc_pkg::CFG_IDX_W-1:0] cfg_index,
	input  wire logic [icsc_pkg::COST_W-1:0]    cfg_data,
	input  wire logic                           load,
	input  wire icsc_pkg::in_beat_t             beat_s1,
	output icsc_pkg::cost_beat_t                beat_s2
);

	logic [icsc_pkg::COST_W-1:0] tensor_cost_q;
	logic [icsc_pkg::COST_W-1:0] scalar_mem_cost_q;
	logic [icsc_pkg::COST_W-1:0] vector_mem_cost_q;
	logic [icsc_pkg::COST_W-1:0] default_cost_q;

	logic [icsc_pkg::COST_W-1:0]                       cost;
	logic [icsc_pkg::COST_W+icsc_pkg::WEIGHT_W-1:0]    product;
	logic [icsc_pkg::WEIGHTED_W-1:0]                   weighted;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tensor_cost_q     <= icsc_pkg::COST_RESET;
			scalar_mem_cost_q <= icsc_pkg::COST_RESET;
			vector_mem_cost_q <= icsc_pkg::COST_RESET;
			default_cost_q    <= icsc_pkg::COST_RESET;
		end else if (cfg_wr_en) begin
			case (cfg_index)
				icsc_pkg::REG_TENSOR_COST:     tensor_cost_q     <= cfg_data;
				icsc_pkg::REG_SCALAR_MEM_COST: scalar_mem_cost_q <= cfg_data;
				icsc_pkg::REG_VECTOR_MEM_COST: vector_mem_cost_q <= cfg_data;
				icsc_pkg::REG_DEFAULT_COST:    default_cost_q    <= cfg_data;
				default: ;
			endcase
		end
	end

	always_comb begin
		case (beat_s1.instr_class)
			icsc_pkg::CLS_SCALAR_MEM: cost = scalar_mem_cost_q;
			icsc_pkg::CLS_VECTOR_MEM: cost = vector_mem_cost_q;
			icsc_pkg::CLS_TENSOR:     cost = tensor_cost_q;
			icsc_pkg::CLS_OTHER:
				cost = (beat_s1.issue_cnt == '0) ? default_cost_q : beat_s1.issue_cnt;
			default:                  cost = beat_s1.issue_cnt;
		endcase
		product = (icsc_pkg::COST_W+icsc_pkg::WEIGHT_W)'(cost)
			* (icsc_pkg::COST_W+icsc_pkg::WEIGHT_W)'(beat_s1.unit_weight);
		if (product[icsc_pkg::COST_W+icsc_pkg::WEIGHT_W-1:icsc_pkg::WEIGHTED_W] != '0)
			weighted = icsc_pkg::WEIGHTED_MAX;
		else
			weighted = product[icsc_pkg::WEIGHTED_W-1:0];
	end

	always_ff @(posedge clk) begin
		if (load) begin
			beat_s2.instr_class <= beat_s1.instr_class;
			beat_s2.cost        <= cost;
			beat_s2.weighted    <= weighted;
		end
	end

endmodule
`default_nettype wire

FILE: rtl/core/icsc_accum.sv
`default_nettype none
module icsc_accum #(
	parameter int unsigned COUNTER_BITS = 48
) (
	input  wire logic                    clk,
	input  wire logic                    arst_n,
	input  wire icsc_pkg::accum_ctl_t    ctl,
	output logic [COUNTER_BITS-1:0]      total_q
);

	localparam logic [COUNTER_BITS-1:0] CNT_MAX = {COUNTER_BITS{1'b1}};

	logic [COUNTER_BITS-1:0] cycle_cnt_q [icsc_pkg::NUM_CYCLE_CLASSES];
	logic [COUNTER_BITS-1:0] inst_cnt_q  [icsc_pkg::NUM_CLASSES];

	icsc_pkg::slot_t        slot;
	logic [COUNTER_BITS:0]  total_sum;

	assign slot      = icsc_pkg::cycle_slot(ctl.beat.instr_class);
	assign total_sum = {1'b0, total_q} + (COUNTER_BITS+1)'(ctl.beat.weighted);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			total_q <= '0;
		end else if (ctl.adv) begin
			total_q <= total_sum[COUNTER_BITS] ? CNT_MAX : total_sum[COUNTER_BITS-1:0];
		end
	end

	for (genvar j = 0; j < icsc_pkg::NUM_CYCLE_CLASSES; j++) begin : g_cycle
		logic [COUNTER_BITS:0] sum;
		assign sum = {1'b0, cycle_cnt_q[j]} + (COUNTER_BITS+1)'(ctl.beat.weighted);
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				cycle_cnt_q[j] <= '0;
			end else if (ctl.adv && slot.cycle_hit
					&& slot.slot == icsc_pkg::SLOT_W'(j)) begin
				cycle_cnt_q[j] <= sum[COUNTER_BITS] ? CNT_MAX : sum[COUNTER_BITS-1:0];
			end
		end
	end

	for (genvar k = 0; k < icsc_pkg::NUM_CLASSES; k++) begin : g_inst
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				inst_cnt_q[k] <= '0;
			end else if (ctl.adv && ctl.beat.instr_class == icsc_pkg::CLASS_W'(k)
					&& inst_cnt_q[k] != CNT_MAX) begin
				inst_cnt_q[k] <= inst_cnt_q[k] + COUNTER_BITS'(1);
			end
		end
	end

endmodule
`default_nettype wire

FILE: rtl/core/instruction_cost_stat_counters.sv
// channel  | handshake              | payload
// ---------+------------------------+-------------------------------------------
// input    | in_valid / in_stall    | instr_class, issue_cnt, unit_weight
// output   | out_valid / out_stall  | cost_out, weighted_out, total_out
// config   | cfg_wr_en              | cfg_index, cfg_data
//
// one beat per cycle while the output is not stalled; each result passes the input, cost and output registers
// stages: input register, cost select and weight multiply, saturating total add
// reset clears all counters and sets the cost registers to one
// an output stall holds the result; in_stall rises once all three stages are full and out_stall is high
`default_nettype none
module instruction_cost_stat_counters #(
	parameter int unsigned COUNTER_BITS = 48
) (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic                              cfg_wr_en,
	input  wire logic [icsc_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  wire logic [icsc_pkg::COST_W-1:0]       cfg_data,
	input  wire logic                              in_valid,
	output logic                                   in_stall,
	input  wire logic [icsc_pkg::CLASS_W-1:0]      instr_class,
	input  wire logic [icsc_pkg::ISSUE_W-1:0]      issue_cnt,
	input  wire logic [icsc_pkg::WEIGHT_W-1:0]     unit_weight,
	output logic                                   out_valid,
	input  wire logic                              out_stall,
	output logic [icsc_pkg::COST_W-1:0]            cost_out,
	output logic [icsc_pkg::WEIGHTED_W-1:0]        weighted_out,
	output logic [icsc_pkg::TOTAL_W-1:0]           total_out
);

	logic valid_s1, valid_s2;
	logic adv_s1, adv_s2, adv_out;

	icsc_pkg::in_beat_t   beat_s1;
	icsc_pkg::cost_beat_t beat_s2;
	icsc_pkg::accum_ctl_t accum_ctl;
	logic [COUNTER_BITS-1:0] total_q;

	assign adv_out  = !out_valid || !out_stall;
	assign adv_s2   = !valid_s2 || adv_out;
	assign adv_s1   = !valid_s1 || adv_s2;
	assign in_stall = !adv_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1  <= 1'b0;
			valid_s2  <= 1'b0;
			out_valid <= 1'b0;
		end else begin
			if (adv_s1)  valid_s1  <= in_valid;
			if (adv_s2)  valid_s2  <= valid_s1;
			if (adv_out) out_valid <= valid_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1 && in_valid) begin
			beat_s1.instr_class <= instr_class;
			beat_s1.issue_cnt   <= issue_cnt;
			beat_s1.unit_weight <= unit_weight;
		end
	end

	icsc_cost_stage u_cost (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_wr_en (cfg_wr_en),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.load      (adv_s2 && valid_s1),
		.beat_s1   (beat_s1),
		.beat_s2   (beat_s2)
	);

	assign accum_ctl.adv  = adv_out && valid_s2;
	assign accum_ctl.beat = beat_s2;

	icsc_accum #(
		.COUNTER_BITS (COUNTER_BITS)
	) u_accum (
		.clk     (clk),
		.arst_n  (arst_n),
		.ctl     (accum_ctl),
		.total_q (total_q)
	);

	always_ff @(posedge clk) begin
		if (accum_ctl.adv) begin
			cost_out     <= beat_s2.cost;
			weighted_out <= beat_s2.weighted;
		end
	end

	assign total_out = icsc_pkg::TOTAL_W'(total_q);

	a_stall_only_when_full: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> (valid_s1 && valid_s2 && out_valid && out_stall))
		else $error("input stalled with room in the pipe");

	a_total_monotonic: assert property (@(posedge clk) disable iff (!arst_n)
		!accum_ctl.adv |=> $stable(total_q))
		else $error("running total moved without a beat");

	a_zero_cost_zero_weight: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && cost_out == '0) |-> (weighted_out == '0))
		else $error("nonzero weighted cost from zero cost");

	a_total_grows: assert property (@(posedge clk) disable iff (!arst_n)
		accum_ctl.adv |=> (total_q >= $past(total_q)))
		else $error("running total decreased");

endmodule
`default_nettype wire

FILE: test/cost_counter_checker.sv
module cost_counter_checker #(
	parameter int unsigned COUNTER_BITS = 48
) (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            cfg_wr_en,
	input  wire logic [icsc_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [icsc_pkg::COST_W-1:0]     cfg_data,
	input  wire logic                            in_valid,
	input  wire logic                            in_stall,
	input  wire logic [icsc_pkg::CLASS_W-1:0]    instr_class,
	input  wire logic [icsc_pkg::ISSUE_W-1:0]    issue_cnt,
	input  wire logic [icsc_pkg::WEIGHT_W-1:0]   unit_weight,
	input  wire logic                            out_valid,
	input  wire logic                            out_stall,
	input  wire logic [icsc_pkg::COST_W-1:0]     cost_out,
	input  wire logic [icsc_pkg::WEIGHTED_W-1:0] weighted_out,
	input  wire logic [icsc_pkg::TOTAL_W-1:0]    total_out,
	output int                                   outstanding,
	output int                                   mismatches,
	output int                                   results_seen
);
	timeunit 1ns;
	timeprecision 1ps;

	localparam logic [63:0] CTR_MAX = (COUNTER_BITS >= 64) ? 64'hFFFF_FFFF_FFFF_FFFF :
		((64'd1 << COUNTER_BITS) - 64'd1);

	typedef struct packed {
		logic [icsc_pkg::COST_W-1:0]     cost;
		logic [icsc_pkg::WEIGHTED_W-1:0] weighted;
		logic [icsc_pkg::TOTAL_W-1:0]    total;
	} charge_t;

	logic [icsc_pkg::COST_W-1:0] tensor_cost_q;
	logic [icsc_pkg::COST_W-1:0] smem_cost_q;
	logic [icsc_pkg::COST_W-1:0] vmem_cost_q;
	logic [icsc_pkg::COST_W-1:0] default_cost_q;
	logic [63:0]       total_work_q;
	logic [63:0]       class_cycles [icsc_pkg::NUM_CYCLE_CLASSES];
	logic [63:0]       class_insts [icsc_pkg::NUM_CLASSES];
	charge_t           expected_charges [$];
	int                errs;
	int                checked;

	function automatic logic [63:0] sat_sum(input logic [63:0] a, input logic [63:0] b);
		if (a >= CTR_MAX || b >= CTR_MAX - a)
			return CTR_MAX;
		return a + b;
	endfunction

	function automatic charge_t charge_instruction(input icsc_pkg::instr_class_t cls,
			input logic [icsc_pkg::ISSUE_W-1:0] issue,
			input logic [icsc_pkg::WEIGHT_W-1:0] weight);
		charge_t     c;
		logic [31:0] product;
		int          slot;
		case (cls)
			icsc_pkg::CLS_SCALAR_MEM: c.cost = smem_cost_q;
			icsc_pkg::CLS_VECTOR_MEM: c.cost = vmem_cost_q;
			icsc_pkg::CLS_TENSOR:     c.cost = tensor_cost_q;
			icsc_pkg::CLS_OTHER:      c.cost = (issue == '0) ? default_cost_q : issue;
			default:                  c.cost = issue;
		endcase
		product = 32'(c.cost) * 32'(weight);
		c.weighted = (product > 32'(icsc_pkg::WEIGHTED_MAX)) ? icsc_pkg::WEIGHTED_MAX :
			product[icsc_pkg::WEIGHTED_W-1:0];
		total_work_q = sat_sum(total_work_q, 64'(c.weighted));
		case (cls)
			icsc_pkg::CLS_SCALAR_ALU: slot = 0;
			icsc_pkg::CLS_SCALAR_MEM: slot = 1;
			icsc_pkg::CLS_VECTOR_ALU: slot = 2;
			icsc_pkg::CLS_VECTOR_MEM: slot = 3;
			icsc_pkg::CLS_SYNC:       slot = 4;
			icsc_pkg::CLS_TENSOR:     slot = 5;
			default:                  slot = -1;
		endcase
		if (slot >= 0)
			class_cycles[slot] = sat_sum(class_cycles[slot], 64'(c.weighted));
		class_insts[cls] = sat_sum(class_insts[cls], 64'd1);
		c.total = total_work_q[icsc_pkg::TOTAL_W-1:0];
		return c;
	endfunction

	always @(posedge clk or negedge arst_n) begin : watch
		charge_t want;
		if (!arst_n) begin
			tensor_cost_q  = icsc_pkg::COST_RESET;
			smem_cost_q    = icsc_pkg::COST_RESET;
			vmem_cost_q    = icsc_pkg::COST_RESET;
			default_cost_q = icsc_pkg::COST_RESET;
			total_work_q   = '0;
			foreach (class_cycles[i])
				class_cycles[i] = '0;
			foreach (class_insts[i])
				class_insts[i] = '0;
			expected_charges.delete();
			errs    = 0;
			checked = 0;
		end else begin
			if (cfg_wr_en) begin
				case (cfg_index)
					icsc_pkg::REG_TENSOR_COST:     tensor_cost_q  = cfg_data;
					icsc_pkg::REG_SCALAR_MEM_COST: smem_cost_q    = cfg_data;
					icsc_pkg::REG_VECTOR_MEM_COST: vmem_cost_q    = cfg_data;
					icsc_pkg::REG_DEFAULT_COST:    default_cost_q = cfg_data;
					default: ;
				endcase
			end
			if (in_valid && !in_stall)
				expected_charges.push_back(charge_instruction(
					icsc_pkg::instr_class_t'(instr_class), issue_cnt, unit_weight));
			if (out_valid && !out_stall) begin
				checked++;
				if (expected_charges.size() == 0) begin
					$error("result beat %0d with none pending: cost %0d weighted %0d total %0d",
						checked, cost_out, weighted_out, total_out);
					errs++;
				end else begin
					want = expected_charges.pop_front();
					if (cost_out !== want.cost) begin
						$error("beat %0d cost_out: expected %0d, got %0d", checked,
							want.cost, cost_out);
						errs++;
					end
					if (weighted_out !== want.weighted) begin
						$error("beat %0d weighted_out: expected %0d, got %0d", checked,
							want.weighted, weighted_out);
						errs++;
					end
					if (total_out !== want.total) begin
						$error("beat %0d total_out: expected %0d, got %0d", checked,
							want.total, total_out);
						errs++;
					end
				end
			end
		end
		outstanding  <= expected_charges.size();
		mismatches   <= errs;
		results_seen <= checked;
	end

endmodule

FILE: test/instruction_cost_stat_counters_tb.sv
module instruction_cost_stat_counters_tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int unsigned COUNTER_BITS    = 48;
	localparam int unsigned CYCLE_LIMIT     = 400000;
	localparam int unsigned SETTLE_CYCLES   = 8;
	localparam int unsigned RANDOM_SEGMENTS = 8;
	localparam int unsigned SEGMENT_ITEMS   = 188;
	localparam int unsigned NUM_COST_REGS   = 4;

	logic                            clk          = 1'b0;
	logic                            arst_n       = 1'b0;
	logic                            cfg_wr_en    = 1'b0;
	logic [icsc_pkg::CFG_IDX_W-1:0]  cfg_index    = '0;
	logic [icsc_pkg::COST_W-1:0]     cfg_data     = '0;
	logic                            in_valid     = 1'b0;
	logic [icsc_pkg::CLASS_W-1:0]    instr_class  = '0;
	logic [icsc_pkg::ISSUE_W-1:0]    issue_cnt    = '0;
	logic [icsc_pkg::WEIGHT_W-1:0]   unit_weight  = '0;
	logic                            out_stall    = 1'b0;
	logic                            in_stall;
	logic                            out_valid;
	logic [icsc_pkg::COST_W-1:0]     cost_out;
	logic [icsc_pkg::WEIGHTED_W-1:0] weighted_out;
	logic [icsc_pkg::TOTAL_W-1:0]    total_out;
	int                              outstanding;
	int                              mismatches;
	int                              results_seen;

	int unsigned idle_pct      = 0;
	int unsigned stall_pct     = 0;
	int unsigned items_sent    = 0;
	int unsigned settings_used = 0;
	int unsigned cycle_count   = 0;

	instruction_cost_stat_counters #(.COUNTER_BITS(COUNTER_BITS)) uut (.*);

	cost_counter_checker #(.COUNTER_BITS(COUNTER_BITS)) watcher (.*);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	always @(posedge clk)
		out_stall <= arst_n && ($urandom_range(99) < stall_pct);

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("instruction_cost_stat_counters regression: fail");
			$finish;
		end
	end

	function automatic logic [icsc_pkg::COST_W-1:0] pick_cost();
		case ($urandom_range(4))
			0:       return '0;
			1:       return '1;
			2:       return icsc_pkg::COST_W'($urandom_range(16));
			default: return icsc_pkg::COST_W'($urandom);
		endcase
	endfunction

	task automatic send_beat(input icsc_pkg::instr_class_t cls,
			input logic [icsc_pkg::ISSUE_W-1:0] issue,
			input logic [icsc_pkg::WEIGHT_W-1:0] weight);
		while ($urandom_range(99) < idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid    <= 1'b1;
		instr_class <= cls;
		issue_cnt   <= issue;
		unit_weight <= weight;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		items_sent++;
	endtask

	task automatic settle();
		in_valid <= 1'b0;
		@(posedge clk);
		while (outstanding != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// unmapped index written last so a decode alias would clobber a live cost
	task automatic program_costs(input logic [icsc_pkg::COST_W-1:0] tensor,
			input logic [icsc_pkg::COST_W-1:0] smem,
			input logic [icsc_pkg::COST_W-1:0] vmem,
			input logic [icsc_pkg::COST_W-1:0] dflt);
		logic [icsc_pkg::CFG_IDX_W-1:0] idx [NUM_COST_REGS+1];
		logic [icsc_pkg::COST_W-1:0]    val [NUM_COST_REGS+1];
		idx[0] = icsc_pkg::REG_TENSOR_COST;
		idx[1] = icsc_pkg::REG_SCALAR_MEM_COST;
		idx[2] = icsc_pkg::REG_VECTOR_MEM_COST;
		idx[3] = icsc_pkg::REG_DEFAULT_COST;
		idx[4] = icsc_pkg::CFG_IDX_W'($urandom_range(2**icsc_pkg::CFG_IDX_W - 1,
			NUM_COST_REGS));
		val[0] = tensor;
		val[1] = smem;
		val[2] = vmem;
		val[3] = dflt;
		val[4] = icsc_pkg::COST_W'($urandom);
		for (int i = 0; i <= NUM_COST_REGS; i++) begin
			cfg_wr_en <= 1'b1;
			cfg_index <= idx[i];
			cfg_data  <= val[i];
			@(posedge clk);
		end
		cfg_wr_en <= 1'b0;
		settings_used++;
	endtask

	initial begin
		logic [icsc_pkg::ISSUE_W-1:0]  issue;
		logic [icsc_pkg::WEIGHT_W-1:0] weight;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset costs of one
		send_beat(icsc_pkg::CLS_SCALAR_ALU, '0, '0);
		send_beat(icsc_pkg::CLS_SCALAR_ALU, '1, 7'd64);
		send_beat(icsc_pkg::CLS_SCALAR_MEM, 16'd1234, 7'd5);
		send_beat(icsc_pkg::CLS_VECTOR_ALU, '1, '1);
		send_beat(icsc_pkg::CLS_VECTOR_MEM, 16'd7, '1);
		send_beat(icsc_pkg::CLS_BRANCH, 16'd100, 7'd3);
		send_beat(icsc_pkg::CLS_SYNC, '1, 7'd1);
		send_beat(icsc_pkg::CLS_TENSOR, '0, 7'd64);
		send_beat(icsc_pkg::CLS_OTHER, '0, 7'd10);
		send_beat(icsc_pkg::CLS_OTHER, 16'd500, 7'd2);

		settle();
		program_costs('1, '1, '1, '1);
		send_beat(icsc_pkg::CLS_TENSOR, '0, '1);
		send_beat(icsc_pkg::CLS_SCALAR_MEM, '0, 7'd64);
		send_beat(icsc_pkg::CLS_VECTOR_MEM, '0, 7'd65);
		send_beat(icsc_pkg::CLS_OTHER, '0, 7'd64);
		send_beat(icsc_pkg::CLS_OTHER, 16'd1, '1);
		send_beat(icsc_pkg::CLS_BRANCH, '1, '1);
		send_beat(icsc_pkg::CLS_SYNC, '0, '1);

		settle();
		program_costs('0, '0, '0, '0);
		send_beat(icsc_pkg::CLS_TENSOR, '1, '1);
		send_beat(icsc_pkg::CLS_SCALAR_MEM, '1, '1);
		send_beat(icsc_pkg::CLS_VECTOR_MEM, '1, '1);
		send_beat(icsc_pkg::CLS_OTHER, '0, '1);
		send_beat(icsc_pkg::CLS_SCALAR_ALU, '0, '1);

		for (int seg = 0; seg < RANDOM_SEGMENTS; seg++) begin
			settle();
			program_costs(pick_cost(), pick_cost(), pick_cost(), pick_cost());
			case (seg / 2)
				0: begin
					idle_pct = 0;
					stall_pct <= 0;
				end
				1: begin
					idle_pct = 80;
					stall_pct <= 0;
				end
				2: begin
					idle_pct = 0;
					stall_pct <= 80;
				end
				default: begin
					idle_pct = 9;
					stall_pct <= 9;
				end
			endcase
			for (int n = 0; n < SEGMENT_ITEMS; n++) begin
				case ($urandom_range(9))
					0:       issue = '0;
					1:       issue = '1;
					2, 3:    issue = icsc_pkg::ISSUE_W'($urandom_range(15));
					default: issue = icsc_pkg::ISSUE_W'($urandom);
				endcase
				case ($urandom_range(9))
					0:       weight = '0;
					1:       weight = 7'd64;
					2:       weight = '1;
					3:       weight = icsc_pkg::WEIGHT_W'($urandom_range(127, 65));
					default: weight = icsc_pkg::WEIGHT_W'($urandom_range(64));
				endcase
				send_beat(icsc_pkg::instr_class_t'($urandom_range(icsc_pkg::NUM_CLASSES - 1)),
					issue, weight);
			end
		end

		settle();
		$display("sent %0d instruction beats under %0d cost settings and four idle/stall mixes",
			items_sent, settings_used);
		$display("compared %0d result beats, %0d field mismatches", results_seen, mismatches);
		if (mismatches == 0)
			$display("instruction_cost_stat_counters regression: pass");
		else
			$display("instruction_cost_stat_counters regression: fail");
		$finish;
	end

endmodule
